@@ hdl/pbdc_pkg.sv @@
// Shared types and constants for the packet buffer with duplicate filter and count.
// Used by pbdc_cell and packet_buffer_with_dedup_and_count_unit; no dependencies.
package pbdc_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned OCC_W  = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 64;
  localparam int unsigned CAP_W  = 7;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned CNT_MAX = 127;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] ACT_ADD     = 2'd0;
  localparam logic [1:0] ACT_FORWARD = 2'd1;
  localparam logic [1:0] ACT_COUNT   = 2'd2;

  typedef struct packed {
    logic shift;
    logic cmp;
    logic scan;
    logic is_add;
  } cell_ctrl_t;

  typedef struct packed {
    logic [WORD_W-1:0] key;
    logic [15:0]       dst;
    logic [31:0]       lo;
    logic [31:0]       hi;
  } query_t;

endpackage

@@ hdl/pbdc_cell.sv @@
// One storage cell of the packet row: packet word, valid flag and match flag.
// Depends on pbdc_pkg for the control and query structs.
module pbdc_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pbdc_pkg::cell_ctrl_t         ctrl_i,
  input  pbdc_pkg::query_t             query_i,
  input  logic                         load_i,
  input  logic                         nbr_valid_i,
  input  logic [pbdc_pkg::WORD_W-1:0]  nbr_word_i,
  input  logic                         nbr_match_i,
  output logic                         valid_o,
  output logic [pbdc_pkg::WORD_W-1:0]  word_o,
  output logic                         match_o
);

  logic                        valid_q, valid_d;
  logic                        match_q, match_d;
  logic [pbdc_pkg::WORD_W-1:0] word_q, word_d;
  logic                        hit_dup, hit_cnt;
  logic [31:0]                 ts;

  assign ts      = word_q[31:0];
  assign hit_dup = valid_q && (word_q == query_i.key);
  assign hit_cnt = valid_q && (word_q[47:32] == query_i.dst) &&
                   (ts >= query_i.lo) && (ts <= query_i.hi);

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    match_d = match_q;
    if (load_i) begin
      valid_d = 1'b1;
      word_d  = query_i.key;
    end else if (ctrl_i.shift) begin
      valid_d = nbr_valid_i;
      word_d  = nbr_word_i;
    end
    if (ctrl_i.cmp) begin
      match_d = ctrl_i.is_add ? hit_dup : hit_cnt;
    end else if (ctrl_i.scan) begin
      match_d = nbr_match_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
  assign match_o = match_q;

endmodule

@@ hdl/packet_buffer_with_dedup_and_count_unit.sv @@
// Forward, unused action or count on empty pass S_EXEC or S_CMP once; add passes S_CMP then S_ADD;
// count passes S_CMP, then S_SCAN once per occupied cell; busy drops as done_o rises.
// Throughput: one request at a time; the count walks match flags down the cell
// row one cell per cycle into a single counter, so its cost grows with occupancy.
// Reset empties the buffer and sets capacity to 64. The receiver cannot stall.
// Top level; depends on pbdc_pkg and pbdc_cell.
module packet_buffer_with_dedup_and_count_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cap_we_i,
  input  logic [pbdc_pkg::CAP_W-1:0]  cap_wdata_i,
  input  logic [1:0]                  action_i,
  input  logic [15:0]                 source_i,
  input  logic [15:0]                 destination_i,
  input  logic [31:0]                 timestamp_i,
  input  logic [31:0]                 start_time_i,
  input  logic [31:0]                 end_time_i,
  output logic                        done_o,
  output logic                        accepted_o,
  output logic                        forward_valid_o,
  output logic [15:0]                 out_source_o,
  output logic [15:0]                 out_destination_o,
  output logic [31:0]                 out_timestamp_o,
  output logic [pbdc_pkg::CNT_W-1:0]  match_count_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_ADD,
    S_SCAN,
    S_EXEC
  } state_e;

  state_e                          state_q;
  logic [1:0]                      act_q;
  pbdc_pkg::query_t                query_q;
  logic [pbdc_pkg::CAP_W-1:0]      cap_q;
  logic [pbdc_pkg::OCC_W-1:0]      occ_q;
  logic [pbdc_pkg::OCC_W-1:0]      left_q;
  logic [pbdc_pkg::OCC_W-1:0]      cnt_q;
  logic                            accept;

  logic [pbdc_pkg::DEPTH:0]        valid_x;
  logic [pbdc_pkg::DEPTH:0]        match_x;
  logic [pbdc_pkg::WORD_W-1:0]     word_x [pbdc_pkg::DEPTH+1];
  logic [pbdc_pkg::DEPTH-1:0]      load;

  pbdc_pkg::cell_ctrl_t            ctrl;
  logic                            dup, full, do_load;
  logic [pbdc_pkg::OCC_W-1:0]      tail, cnt_next;
  logic [31:0]                     cap_eff, cnt_ext;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  assign dup = |match_x[pbdc_pkg::DEPTH-1:0];

  always_comb begin
    cap_eff = 32'(cap_q);
    if (cap_eff == 32'd0) cap_eff = 32'd1;
    if (cap_eff > 32'(pbdc_pkg::DEPTH)) cap_eff = 32'(pbdc_pkg::DEPTH);
  end
  assign full = 32'(occ_q) >= cap_eff;
  assign tail = full ? occ_q - pbdc_pkg::OCC_W'(1) : occ_q;

  always_comb begin
    ctrl        = '0;
    ctrl.is_add = (act_q == pbdc_pkg::ACT_ADD);
    ctrl.cmp    = (state_q == S_CMP);
    ctrl.scan   = (state_q == S_SCAN);
    do_load     = (state_q == S_ADD) && !dup;
    if (do_load && full) ctrl.shift = 1'b1;
    if (state_q == S_EXEC && act_q == pbdc_pkg::ACT_FORWARD && occ_q != '0) begin
      ctrl.shift = 1'b1;
    end
  end

  assign valid_x[pbdc_pkg::DEPTH] = 1'b0;
  assign match_x[pbdc_pkg::DEPTH] = 1'b0;
  assign word_x[pbdc_pkg::DEPTH]  = '0;

  for (genvar g = 0; g < pbdc_pkg::DEPTH; g++) begin : g_cell
    assign load[g] = do_load && (tail == pbdc_pkg::OCC_W'(g));
    pbdc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .query_i     (query_q),
      .load_i      (load[g]),
      .nbr_valid_i (valid_x[g+1]),
      .nbr_word_i  (word_x[g+1]),
      .nbr_match_i (match_x[g+1]),
      .valid_o     (valid_x[g]),
      .word_o      (word_x[g]),
      .match_o     (match_x[g])
    );
  end

  assign cnt_next = cnt_q + pbdc_pkg::OCC_W'(match_x[0]);
  assign cnt_ext  = 32'(cnt_next);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      query_q.key <= {source_i, destination_i, timestamp_i};
      query_q.dst <= destination_i;
      query_q.lo  <= start_time_i;
      query_q.hi  <= end_time_i;
      act_q       <= action_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      cap_q             <= pbdc_pkg::CAP_RESET;
      occ_q             <= '0;
      left_q            <= '0;
      cnt_q             <= '0;
      done_o            <= 1'b0;
      accepted_o        <= 1'b0;
      forward_valid_o   <= 1'b0;
      out_source_o      <= '0;
      out_destination_o <= '0;
      out_timestamp_o   <= '0;
      match_count_o     <= '0;
    end else begin
      if (cap_we_i) cap_q <= cap_wdata_i;
      done_o            <= 1'b0;
      accepted_o        <= 1'b0;
      forward_valid_o   <= 1'b0;
      out_source_o      <= '0;
      out_destination_o <= '0;
      out_timestamp_o   <= '0;
      match_count_o     <= '0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (action_i inside {pbdc_pkg::ACT_ADD, pbdc_pkg::ACT_COUNT}) begin
              state_q <= S_CMP;
            end else begin
              state_q <= S_EXEC;
            end
          end
        end
        S_CMP: begin
          if (act_q == pbdc_pkg::ACT_ADD) begin
            state_q <= S_ADD;
          end else if (occ_q == '0) begin
            done_o  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            left_q  <= occ_q;
            cnt_q   <= '0;
            state_q <= S_SCAN;
          end
        end
        S_ADD: begin
          done_o  <= 1'b1;
          state_q <= S_IDLE;
          if (!dup) begin
            accepted_o <= 1'b1;
            if (!full) occ_q <= occ_q + pbdc_pkg::OCC_W'(1);
          end
        end
        S_SCAN: begin
          cnt_q  <= cnt_next;
          left_q <= left_q - pbdc_pkg::OCC_W'(1);
          if (left_q == pbdc_pkg::OCC_W'(1)) begin
            done_o        <= 1'b1;
            match_count_o <= (cnt_ext > 32'(pbdc_pkg::CNT_MAX)) ?
                             pbdc_pkg::CNT_W'(pbdc_pkg::CNT_MAX) : cnt_ext[pbdc_pkg::CNT_W-1:0];
            state_q       <= S_IDLE;
          end
        end
        S_EXEC: begin
          done_o  <= 1'b1;
          state_q <= S_IDLE;
          if (act_q == pbdc_pkg::ACT_FORWARD && occ_q != '0) begin
            forward_valid_o   <= 1'b1;
            out_source_o      <= word_x[0][63:48];
            out_destination_o <= word_x[0][47:32];
            out_timestamp_o   <= word_x[0][31:0];
            occ_q             <= occ_q - pbdc_pkg::OCC_W'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ dv/tb_packet_buffer_with_dedup_and_count_unit.sv @@
// Self-checking testbench for the packet buffer with duplicate filter and range count.
// Drives requests over start/busy, predicts each done_o beat, compares field by field.
// Depends on pbdc_pkg and packet_buffer_with_dedup_and_count_unit.
module tb_packet_buffer_with_dedup_and_count_unit;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned PHASE_BEATS = 125;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] source;
    logic [15:0] destination;
    logic [31:0] timestamp;
    logic [31:0] start_time;
    logic [31:0] end_time;
  } pkt_req_t;

  typedef struct packed {
    logic                       accepted;
    logic                       forward_valid;
    logic [15:0]                out_source;
    logic [15:0]                out_destination;
    logic [31:0]                out_timestamp;
    logic [pbdc_pkg::CNT_W-1:0] match_count;
  } pkt_resp_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       cap_we_i = 1'b0;
  logic [pbdc_pkg::CAP_W-1:0] cap_wdata_i = '0;
  logic [1:0]                 action_i = '0;
  logic [15:0]                source_i = '0;
  logic [15:0]                destination_i = '0;
  logic [31:0]                timestamp_i = '0;
  logic [31:0]                start_time_i = '0;
  logic [31:0]                end_time_i = '0;
  logic                       done_o;
  logic                       accepted_o;
  logic                       forward_valid_o;
  logic [15:0]                out_source_o;
  logic [15:0]                out_destination_o;
  logic [31:0]                out_timestamp_o;
  logic [pbdc_pkg::CNT_W-1:0] match_count_o;

  packet_buffer_with_dedup_and_count_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .cap_we_i          (cap_we_i),
    .cap_wdata_i       (cap_wdata_i),
    .action_i          (action_i),
    .source_i          (source_i),
    .destination_i     (destination_i),
    .timestamp_i       (timestamp_i),
    .start_time_i      (start_time_i),
    .end_time_i        (end_time_i),
    .done_o            (done_o),
    .accepted_o        (accepted_o),
    .forward_valid_o   (forward_valid_o),
    .out_source_o      (out_source_o),
    .out_destination_o (out_destination_o),
    .out_timestamp_o   (out_timestamp_o),
    .match_count_o     (match_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Predicted buffer contents
  logic [pbdc_pkg::WORD_W-1:0] buf_word [pbdc_pkg::DEPTH];
  bit                          buf_live [pbdc_pkg::DEPTH];
  int unsigned                 buf_fill;
  int unsigned                 buf_head;
  logic [pbdc_pkg::CAP_W-1:0]  cap_setting;

  pkt_resp_t   expected_resp_q [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          gaps_on;
  int unsigned burst_left;
  int unsigned n_add, n_refused, n_forward, n_empty_fwd, n_count, n_none, n_cap_writes;

  function automatic void drop_oldest_packet();
    if (buf_fill != 0) begin
      buf_live[buf_head] = 1'b0;
      buf_head = (buf_head + 1) % pbdc_pkg::DEPTH;
      buf_fill--;
    end
  endfunction

  function automatic pkt_resp_t predict_response(pkt_req_t r);
    pkt_resp_t o;
    logic [pbdc_pkg::WORD_W-1:0] word;
    bit dup;
    int unsigned eff_cap, hits, tail;
    o = '0;
    eff_cap = (cap_setting == 0) ? 1 :
              ((cap_setting > pbdc_pkg::DEPTH) ? pbdc_pkg::DEPTH : cap_setting);
    case (r.action)
      pbdc_pkg::ACT_ADD: begin
        n_add++;
        word = {r.source, r.destination, r.timestamp};
        dup = 1'b0;
        for (int i = 0; i < pbdc_pkg::DEPTH; i++)
          if (buf_live[i] && buf_word[i] == word) dup = 1'b1;
        if (dup) begin
          n_refused++;
        end else begin
          if (buf_fill >= eff_cap) drop_oldest_packet();
          tail = (buf_head + buf_fill) % pbdc_pkg::DEPTH;
          buf_word[tail] = word;
          buf_live[tail] = 1'b1;
          buf_fill++;
          o.accepted = 1'b1;
        end
      end
      pbdc_pkg::ACT_FORWARD: begin
        n_forward++;
        if (buf_fill == 0) begin
          n_empty_fwd++;
        end else begin
          word = buf_word[buf_head];
          o.forward_valid = 1'b1;
          o.out_source = word[63:48];
          o.out_destination = word[47:32];
          o.out_timestamp = word[31:0];
          drop_oldest_packet();
        end
      end
      pbdc_pkg::ACT_COUNT: begin
        n_count++;
        hits = 0;
        for (int i = 0; i < pbdc_pkg::DEPTH; i++)
          if (buf_live[i] && buf_word[i][47:32] == r.destination &&
              buf_word[i][31:0] >= r.start_time && buf_word[i][31:0] <= r.end_time)
            hits++;
        if (hits > pbdc_pkg::CNT_MAX) hits = pbdc_pkg::CNT_MAX;
        o.match_count = hits[pbdc_pkg::CNT_W-1:0];
      end
      default: n_none++;
    endcase
    return o;
  endfunction

  function automatic pkt_req_t make_req(logic [1:0] act, logic [15:0] src, logic [15:0] dst,
                                        logic [31:0] ts, logic [31:0] lo, logic [31:0] hi);
    pkt_req_t r;
    r.action = act;
    r.source = src;
    r.destination = dst;
    r.timestamp = ts;
    r.start_time = lo;
    r.end_time = hi;
    return r;
  endfunction

  function automatic logic [15:0] rand_id();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 16'hFFFF));
      1: return 16'(16'hFFFF - $urandom_range(0, 3));
      default: return 16'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [31:0] rand_stamp();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, 7);
      default: return $urandom_range(0, 31);
    endcase
  endfunction

  function automatic pkt_req_t rand_request(int unsigned add_pct, int unsigned fwd_pct);
    pkt_req_t r;
    int unsigned roll, slot;
    r = make_req(ACT_NONE, rand_id(), rand_id(), rand_stamp(), $urandom(), $urandom());
    roll = $urandom_range(0, 99);
    if (roll < add_pct) begin
      r.action = pbdc_pkg::ACT_ADD;
      if (buf_fill != 0 && $urandom_range(0, 4) == 0) begin
        slot = (buf_head + $urandom_range(0, buf_fill - 1)) % pbdc_pkg::DEPTH;
        {r.source, r.destination, r.timestamp} = buf_word[slot];
      end
    end else if (roll < add_pct + fwd_pct) begin
      r.action = pbdc_pkg::ACT_FORWARD;
    end else if (roll < 97) begin
      r.action = pbdc_pkg::ACT_COUNT;
      case ($urandom_range(0, 7))
        0: {r.start_time, r.end_time} = {32'h0, 32'hFFFF_FFFF};
        1: ;
        2: begin
          r.start_time = rand_stamp();
          r.end_time = r.start_time;
        end
        3: begin
          r.end_time = $urandom_range(0, 31);
          r.start_time = r.end_time + 32'd1;
        end
        4: {r.start_time, r.end_time} = {32'hFFFF_FFF0, 32'hFFFF_FFFF};
        default: begin
          r.start_time = $urandom_range(0, 31);
          r.end_time = r.start_time + $urandom_range(0, 16);
        end
      endcase
    end
    return r;
  endfunction

  task automatic idle_sender(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold start high across back-to-back beats; lower it only on a gap.
  task automatic send_item(input pkt_req_t r);
    if (gaps_on && burst_left == 0) begin
      idle_sender($urandom_range(1, 8));
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    start         <= 1'b1;
    action_i      <= r.action;
    source_i      <= r.source;
    destination_i <= r.destination;
    timestamp_i   <= r.timestamp;
    start_time_i  <= r.start_time;
    end_time_i    <= r.end_time;
    do @(posedge clk_i); while (busy);
    expected_resp_q.insert(expected_resp_q.size(), predict_response(r));
  endtask

  task automatic write_capacity(input logic [pbdc_pkg::CAP_W-1:0] value);
    idle_sender(0);
    while (expected_resp_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cap_we_i    <= 1'b1;
    cap_wdata_i <= value;
    @(posedge clk_i);
    cap_setting = value;
    n_cap_writes++;
    cap_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : check_beat
    pkt_resp_t want;
    if (rst_ni && done_o) begin
      if (expected_resp_q.size() == 0) begin
        $error("result beat with no request pending");
        mismatch_count++;
      end else begin
        want = expected_resp_q.pop_front();
        if (accepted_o !== want.accepted) begin
          $error("accepted: expected %0h, actual %0h", want.accepted, accepted_o);
          mismatch_count++;
        end
        if (forward_valid_o !== want.forward_valid) begin
          $error("forward_valid: expected %0h, actual %0h", want.forward_valid, forward_valid_o);
          mismatch_count++;
        end
        if (out_source_o !== want.out_source) begin
          $error("out_source: expected %0h, actual %0h", want.out_source, out_source_o);
          mismatch_count++;
        end
        if (out_destination_o !== want.out_destination) begin
          $error("out_destination: expected %0h, actual %0h",
                 want.out_destination, out_destination_o);
          mismatch_count++;
        end
        if (out_timestamp_o !== want.out_timestamp) begin
          $error("out_timestamp: expected %0h, actual %0h", want.out_timestamp, out_timestamp_o);
          mismatch_count++;
        end
        if (match_count_o !== want.match_count) begin
          $error("match_count: expected %0d, actual %0d", want.match_count, match_count_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run exceeded %0d cycles with %0d results outstanding",
               CYCLE_LIMIT, expected_resp_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_empty_buffer();
    send_item(make_req(pbdc_pkg::ACT_FORWARD, 16'hFFFF, 16'hFFFF, '1, '1, '1));
    send_item(make_req(pbdc_pkg::ACT_COUNT, 16'h0, 16'h0, 32'h0, 32'h0, 32'hFFFF_FFFF));
    send_item(make_req(ACT_NONE, 16'hFFFF, 16'hFFFF, '1, '1, '1));
  endtask

  task automatic test_field_extremes();
    send_item(make_req(pbdc_pkg::ACT_ADD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0));
    send_item(make_req(pbdc_pkg::ACT_ADD, 16'hFFFF, 16'hFFFF, '1, '1, '1));
    send_item(make_req(pbdc_pkg::ACT_COUNT, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0));
    send_item(make_req(pbdc_pkg::ACT_COUNT, 16'h0, 16'hFFFF, 32'h0, 32'h0, 32'hFFFF_FFFF));
    send_item(make_req(pbdc_pkg::ACT_COUNT, 16'h0, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'h0));
    send_item(make_req(ACT_NONE, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0));
    send_item(make_req(pbdc_pkg::ACT_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0));
    send_item(make_req(pbdc_pkg::ACT_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0));
  endtask

  task automatic test_duplicate_filter();
    write_capacity(7'd2);
    send_item(make_req(pbdc_pkg::ACT_ADD, 16'd1, 16'd2, 32'd100, 32'd0, 32'd0));
    send_item(make_req(pbdc_pkg::ACT_ADD, 16'd1, 16'd2, 32'd101, 32'd0, 32'd0));
    send_item(make_req(pbdc_pkg::ACT_ADD, 16'd1, 16'd2, 32'd100, 32'd0, 32'd0));
    send_item(make_req(pbdc_pkg::ACT_ADD, 16'd3, 16'd4, 32'd5, 32'd0, 32'd0));
    send_item(make_req(pbdc_pkg::ACT_ADD, 16'd1, 16'd2, 32'd100, 32'd0, 32'd0));
    send_item(make_req(pbdc_pkg::ACT_COUNT, 16'd0, 16'd2, 32'd0, 32'd100, 32'd101));
    send_item(make_req(pbdc_pkg::ACT_FORWARD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0));
    send_item(make_req(pbdc_pkg::ACT_FORWARD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0));
  endtask

  task automatic test_capacity_limits();
    write_capacity(7'd0);
    send_item(make_req(pbdc_pkg::ACT_ADD, 16'd7, 16'd8, 32'd9, 32'd0, 32'd0));
    send_item(make_req(pbdc_pkg::ACT_ADD, 16'd7, 16'd8, 32'd10, 32'd0, 32'd0));
    send_item(make_req(pbdc_pkg::ACT_FORWARD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0));
    send_item(make_req(pbdc_pkg::ACT_FORWARD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0));
    write_capacity(7'd127);
    send_item(make_req(pbdc_pkg::ACT_ADD, 16'd1, 16'd4, 32'd1, 32'd0, 32'd0));
    send_item(make_req(pbdc_pkg::ACT_ADD, 16'd2, 16'd4, 32'd2, 32'd0, 32'd0));
    send_item(make_req(pbdc_pkg::ACT_ADD, 16'd3, 16'd4, 32'd3, 32'd0, 32'd0));
    write_capacity(7'd1);
    send_item(make_req(pbdc_pkg::ACT_ADD, 16'd5, 16'd4, 32'd4, 32'd0, 32'd0));
    send_item(make_req(pbdc_pkg::ACT_COUNT, 16'd0, 16'd4, 32'd0, 32'd0, 32'hFFFF_FFFF));
  endtask

  task automatic test_random_traffic();
    logic [pbdc_pkg::CAP_W-1:0] caps [10] = '{7'd64, 7'd1, 7'd0, 7'd3, 7'd127,
                                              7'd2, 7'd40, 7'd64, 7'd8, 7'd100};
    int unsigned add_pct, fwd_pct;
    for (int p = 0; p < 10; p++) begin
      write_capacity(caps[p]);
      gaps_on = (p % 3 != 0);
      burst_left = 0;
      add_pct = (p % 2 == 0) ? 65 : 40;
      fwd_pct = (p % 2 == 0) ? 10 : 30;
      repeat (PHASE_BEATS) send_item(rand_request(add_pct, fwd_pct));
    end
  endtask

  initial begin
    cap_setting = pbdc_pkg::CAP_RESET;
    buf_fill = 0;
    buf_head = 0;
    foreach (buf_live[i]) buf_live[i] = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_buffer();
    test_field_extremes();
    test_duplicate_filter();
    test_capacity_limits();
    test_random_traffic();
    idle_sender(0);
    while (expected_resp_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("covered %0d adds (%0d refused as duplicate), %0d forwards (%0d on empty),",
             n_add, n_refused, n_forward, n_empty_fwd);
    $display("  %0d counts, %0d unused actions, %0d capacity writes; %0d mismatches",
             n_count, n_none, n_cap_writes, mismatch_count);
    if (mismatch_count == 0 && expected_resp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
